/* rtl/core/cpqpm_pkg.sv */
// Shared constants and field widths of the constant-power quad pan mixer.
package cpqpm_pkg;

  // Channel count is fixed by the port list (one sample port per channel).
  localparam int CHANNELS = 4;
  localparam int CH_W     = $clog2(CHANNELS);

  // Field widths.
  localparam int SAMPLE_W = 16;
  localparam int PAN_W    = 11;
  localparam int LEVEL_W  = 16;
  localparam int GAIN_W   = 16;
  localparam int OUT_W    = 18;
  localparam int CFG_W    = 16;

  // Configuration register map.
  localparam int CFG_REGS       = 2 * CHANNELS;
  localparam int CFG_IDX_W      = $clog2(CFG_REGS);
  localparam int REG_PAN_BASE   = 0;
  localparam int REG_LEVEL_BASE = CHANNELS;

  // Reset values and fixed-point constants.
  localparam int unsigned PAN_RESET   = 512;
  localparam int unsigned LEVEL_RESET = 22938;
  localparam int unsigned UNITY_Q15   = 32768;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  localparam int DEF_PAN_STEPS = 1024;

endpackage

/* rtl/core/constant_power_quad_pan_mixer.sv */
// Four-channel constant-power stereo pan mixer with a three-stage datapath.
//
// Accepts one frame of four signed samples per cycle while input ready is high and
// returns one stereo result per frame, registered in turn by the product, pair-sum
// and output stages; valid bits travel with the data through those stages, so a
// stall on the output side holds every stage and loses nothing. The per-channel
// left and right gains (cos and sin of the pan angle times the level, both Q15)
// live in registers that a small sequencer rebuilds from the quarter-sine ROM, one
// channel per cycle, after reset and after every configuration write. That refresh
// holds input ready low from the write or the reset release until the last gains
// are stored. The ROM has PAN_STEPS + 1 entries and two read ports, one for the
// sine and one for the cosine address of the channel being refreshed.
module constant_power_quad_pan_mixer
  import cpqpm_pkg::*;
#(
  parameter int PAN_STEPS = DEF_PAN_STEPS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port.
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [CFG_W-1:0]            cfg_wdata_i,
  // Input request channel.
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic signed [SAMPLE_W-1:0]  sample_ch0_i,
  input  logic signed [SAMPLE_W-1:0]  sample_ch1_i,
  input  logic signed [SAMPLE_W-1:0]  sample_ch2_i,
  input  logic signed [SAMPLE_W-1:0]  sample_ch3_i,
  // Output request channel.
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic signed [OUT_W-1:0]     left_sum_o,
  output logic signed [OUT_W-1:0]     right_sum_o
);

  localparam int RomAw  = $clog2(PAN_STEPS + 1);
  localparam int ProdW  = SAMPLE_W + GAIN_W - 1;
  localparam int MulW   = SAMPLE_W + GAIN_W + 1;
  localparam int Pairs  = CHANNELS / 2;

  typedef logic [GAIN_W-1:0] rom_t [PAN_STEPS+1];

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_SWEEP = 2'b10
  } refresh_state_e;

  // The quarter-sine table is built at elaboration from a Taylor series in Q30.
  function automatic rom_t build_rom();
    rom_t              r;
    longint unsigned   x;
    longint unsigned   x2;
    longint unsigned   term;
    longint            acc;
    longint            q;
    for (int k = 0; k <= PAN_STEPS; k++) begin
      x    = (longint'(k) * HALF_PI_Q30) / PAN_STEPS;
      x2   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      term = ((term * x2) >> 30) / 6;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 20;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 42;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 72;
      acc  = acc + longint'(term);
      term = ((term * x2) >> 30) / 110;
      acc  = acc - longint'(term);
      term = ((term * x2) >> 30) / 156;
      acc  = acc + longint'(term);
      if (acc < 0) begin
        acc = 0;
      end
      q = (acc + 16384) >>> 15;
      if (q > longint'(UNITY_Q15)) begin
        q = longint'(UNITY_Q15);
      end
      r[k] = GAIN_W'(q);
    end
    return r;
  endfunction

  localparam rom_t SineRom = build_rom();

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [PAN_W-1:0]   pan_q   [CHANNELS];
  logic [LEVEL_W-1:0] level_q [CHANNELS];
  logic [CH_W-1:0]    cfg_ch;
  logic               cfg_is_pan;

  assign cfg_ch     = cfg_idx_i[CH_W-1:0];
  assign cfg_is_pan = (cfg_idx_i < CFG_IDX_W'(REG_LEVEL_BASE)) &&
                      (cfg_idx_i >= CFG_IDX_W'(REG_PAN_BASE));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNELS; c++) begin
        pan_q[c]   <= PAN_W'(PAN_RESET);
        level_q[c] <= LEVEL_W'(LEVEL_RESET);
      end
    end else if (cfg_we_i) begin
      if (cfg_is_pan) begin
        pan_q[cfg_ch] <= cfg_wdata_i[PAN_W-1:0];
      end else begin
        level_q[cfg_ch] <= cfg_wdata_i[LEVEL_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Gain refresh: sweep the channels, read sine and cosine, scale by the level.
  // ---------------------------------------------------------------------------
  refresh_state_e     st_q, st_d;
  logic [CH_W-1:0]    sweep_ch_q, sweep_ch_d;
  logic               r1_valid_q;
  logic [CH_W-1:0]    r1_ch_q;
  logic [GAIN_W-1:0]  rom_sin_q, rom_cos_q;
  logic [PAN_W-1:0]   pan_sel;
  logic               pan_over;
  logic [RomAw-1:0]   addr_sin, addr_cos;
  logic [LEVEL_W-1:0] lvl_sel, lvl_sat;
  logic [2*GAIN_W-1:0] gl_full, gr_full;
  logic [GAIN_W-1:0]  gain_l_q [CHANNELS];
  logic [GAIN_W-1:0]  gain_r_q [CHANNELS];
  logic               refresh_busy;

  always_comb begin
    st_d       = st_q;
    sweep_ch_d = sweep_ch_q;
    case (st_q)
      ST_IDLE: begin
        sweep_ch_d = '0;
      end
      ST_SWEEP: begin
        sweep_ch_d = sweep_ch_q + 1'b1;
        if (sweep_ch_q == CH_W'(CHANNELS - 1)) begin
          st_d       = ST_IDLE;
          sweep_ch_d = '0;
        end
      end
      default: begin
        st_d       = ST_SWEEP;
        sweep_ch_d = '0;
      end
    endcase
    // Any register write invalidates the gains, so the sweep starts over.
    if (cfg_we_i) begin
      st_d       = ST_SWEEP;
      sweep_ch_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_SWEEP;
      sweep_ch_q <= '0;
      r1_valid_q <= 1'b0;
    end else begin
      st_q       <= st_d;
      sweep_ch_q <= sweep_ch_d;
      r1_valid_q <= (st_q == ST_SWEEP);
    end
  end

  assign pan_sel  = pan_q[sweep_ch_q];
  assign pan_over = 32'(pan_sel) > 32'(PAN_STEPS);
  assign addr_sin = pan_over ? RomAw'(PAN_STEPS) : RomAw'(pan_sel);
  assign addr_cos = RomAw'(PAN_STEPS) - addr_sin;

  always_ff @(posedge clk_i) begin
    rom_sin_q <= SineRom[addr_sin];
    rom_cos_q <= SineRom[addr_cos];
    r1_ch_q   <= sweep_ch_q;
  end

  assign lvl_sel = level_q[r1_ch_q];
  assign lvl_sat = (32'(lvl_sel) > UNITY_Q15) ? LEVEL_W'(UNITY_Q15) : lvl_sel;
  assign gl_full = rom_cos_q * lvl_sat;
  assign gr_full = rom_sin_q * lvl_sat;

  always_ff @(posedge clk_i) begin
    if (r1_valid_q) begin
      gain_l_q[r1_ch_q] <= gl_full[GAIN_W+14:15];
      gain_r_q[r1_ch_q] <= gr_full[GAIN_W+14:15];
    end
  end

  assign refresh_busy = (st_q == ST_SWEEP) || r1_valid_q;

  // ---------------------------------------------------------------------------
  // Datapath: products, pair sums, output register.
  // ---------------------------------------------------------------------------
  logic                     v1_q, v2_q, v3_q;
  logic                     en1, en2, en3;
  logic                     accept;
  logic signed [SAMPLE_W-1:0] samp [CHANNELS];
  logic signed [MulW-1:0]   mul_l [CHANNELS];
  logic signed [MulW-1:0]   mul_r [CHANNELS];
  logic signed [ProdW-1:0]  prod_l_q [CHANNELS];
  logic signed [ProdW-1:0]  prod_r_q [CHANNELS];
  logic signed [OUT_W-1:0]  contrib_l [CHANNELS];
  logic signed [OUT_W-1:0]  contrib_r [CHANNELS];
  logic signed [OUT_W-1:0]  pair_l_q [Pairs];
  logic signed [OUT_W-1:0]  pair_r_q [Pairs];
  logic signed [OUT_W-1:0]  left_q, right_q;

  assign samp[0] = sample_ch0_i;
  assign samp[1] = sample_ch1_i;
  assign samp[2] = sample_ch2_i;
  assign samp[3] = sample_ch3_i;

  assign en3    = !v3_q || out_ready_i;
  assign en2    = !v2_q || en3;
  assign en1    = !v1_q || en2;
  assign in_ready_o = en1 && !refresh_busy && !cfg_we_i;
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      mul_l[c] = samp[c] * $signed({1'b0, gain_l_q[c]});
      mul_r[c] = samp[c] * $signed({1'b0, gain_r_q[c]});
      // Bits 30..15 of the product are the floor of the product over 2^15.
      contrib_l[c] = OUT_W'($signed(prod_l_q[c][ProdW-1:15]));
      contrib_r[c] = OUT_W'($signed(prod_r_q[c][ProdW-1:15]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= accept;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int c = 0; c < CHANNELS; c++) begin
        prod_l_q[c] <= mul_l[c][ProdW-1:0];
        prod_r_q[c] <= mul_r[c][ProdW-1:0];
      end
    end
    if (en2 && v1_q) begin
      for (int p = 0; p < Pairs; p++) begin
        pair_l_q[p] <= contrib_l[2*p] + contrib_l[2*p+1];
        pair_r_q[p] <= contrib_r[2*p] + contrib_r[2*p+1];
      end
    end
    if (en3 && v2_q) begin
      left_q  <= pair_l_q[0] + pair_l_q[1];
      right_q <= pair_r_q[0] + pair_r_q[1];
    end
  end

  assign out_valid_o = v3_q;
  assign left_sum_o  = left_q;
  assign right_sum_o = right_q;

`ifndef SYNTHESIS
  // A register write must block the very next request until the gains are rebuilt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !(in_valid_i && in_ready_o))
    else $error("request accepted right after a configuration write");

  // A product-stage item moves into the pair-sum stage when that stage can take it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v1_q && en2) |=> v2_q)
    else $error("item lost between product and pair-sum stages");

  // The sweep counter rests at channel zero whenever no refresh is running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_IDLE) |-> (sweep_ch_q == '0))
    else $error("sweep counter not parked while idle");
`endif

endmodule
